// ===== rtl/gasp_pkg.sv =====
// Shared types, constants and helper functions of the grid path search engine.
// Used by gasp_tile_store and grid_astar_path_search; depends on nothing.
package gasp_pkg;

   localparam int COORD_W = 8;
   localparam int TILE_AW = 2 * COORD_W;
   localparam logic [COORD_W-1:0] MAP_LAST = '1;
   localparam int NODE_POOL = 4096;
   localparam int NODE_AW = $clog2(NODE_POOL);
   localparam int NODE_W = NODE_AW + 1;
   localparam logic [NODE_W-1:0] NODE_NIL = '1;
   localparam int HINT_W = 13;
   localparam int COST_W = 16;
   localparam int TOTAL_W = COST_W + 1;
   localparam int DIR_W = 4;
   localparam int DIST_W = 9;
   localparam int HEUR_W = 10;
   localparam int BESTD_W = 10;
   localparam logic [BESTD_W-1:0] BESTD_INIT = 10'd999;
   localparam int LIM_W = 15;
   localparam int BUDGET_PER_STEP = 20;
   localparam int BUDGET_BASE = 500;
   localparam logic [COST_W-1:0] STEP_STRAIGHT = 16'd2;
   localparam logic [COST_W-1:0] STEP_DIAG = 16'd3;
   localparam logic [DIR_W-1:0] DIR_NONE = '0;
   localparam int FLAG_W = 3;
   localparam int FLAG_BLOCK = 0;
   localparam int FLAG_DOOR = 1;
   localparam int FLAG_TEMP = 2;
   localparam logic ACT_WRITE = 1'b0;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 8;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_REJECT    = 2'd2,
      ST_WRITE     = 2'd3
   } status_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_USE_RECT = 3'd0,
      CSR_X_LOW    = 3'd1,
      CSR_X_HIGH   = 3'd2,
      CSR_Y_LOW    = 3'd3,
      CSR_Y_HIGH   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               enable;
      logic [COORD_W-1:0] x_low;
      logic [COORD_W-1:0] x_high;
      logic [COORD_W-1:0] y_low;
      logic [COORD_W-1:0] y_high;
   } rect_type;

   typedef struct packed {
      logic               flag_we;
      logic [TILE_AW-1:0] flag_wa;
      logic [FLAG_W-1:0]  flag_wd;
      logic [TILE_AW-1:0] flag_ra;
      logic               slot_we;
      logic [TILE_AW-1:0] slot_wa;
      logic [NODE_W-1:0]  slot_wd;
      logic [TILE_AW-1:0] slot_ra;
   } tile_port_type;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [DIST_W-1:0] mdist(input logic [COORD_W-1:0] ax,
                                               input logic [COORD_W-1:0] ay,
                                               input logic [COORD_W-1:0] bx,
                                               input logic [COORD_W-1:0] by);
      return DIST_W'(abs_diff(ax, bx)) + DIST_W'(abs_diff(ay, by));
   endfunction

   function automatic logic [HEUR_W-1:0] heur(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y,
                                              input logic [COORD_W-1:0] tx,
                                              input logic [COORD_W-1:0] ty);
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      dx = abs_diff(x, tx);
      dy = abs_diff(y, ty);
      if (dx > dy) begin
         return HEUR_W'({dx, 1'b0}) + HEUR_W'(dy);
      end
      return HEUR_W'({dy, 1'b0}) + HEUR_W'(dx);
   endfunction

   function automatic logic passable(input logic [COORD_W:0] x,
                                     input logic [COORD_W:0] y,
                                     input logic [FLAG_W-1:0] f,
                                     input rect_type r);
      logic ok;
      ok = !x[COORD_W] && !y[COORD_W];
      if (r.enable && (x[COORD_W-1:0] < r.x_low || x[COORD_W-1:0] > r.x_high ||
                       y[COORD_W-1:0] < r.y_low || y[COORD_W-1:0] > r.y_high)) begin
         ok = 1'b0;
      end
      if (f[FLAG_BLOCK]) begin
         ok = 1'b0;
      end else if (!f[FLAG_DOOR] && f[FLAG_TEMP]) begin
         ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [COORD_W:0] nb_x(input logic [COORD_W-1:0] x,
                                             input logic [2:0] k);
      logic [COORD_W:0] r;
      unique case (k)
         3'd0, 3'd4, 3'd5: r = (COORD_W+1)'(x) + 1'b1;
         3'd1, 3'd6, 3'd7: r = (COORD_W+1)'(x) - 1'b1;
         default:          r = (COORD_W+1)'(x);
      endcase
      return r;
   endfunction

   function automatic logic [COORD_W:0] nb_y(input logic [COORD_W-1:0] y,
                                             input logic [2:0] k);
      logic [COORD_W:0] r;
      unique case (k)
         3'd2, 3'd4, 3'd6: r = (COORD_W+1)'(y) + 1'b1;
         3'd3, 3'd5, 3'd7: r = (COORD_W+1)'(y) - 1'b1;
         default:          r = (COORD_W+1)'(y);
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/gasp_tile_store.sv =====
// Per-tile flag memory and per-tile node slot memory of the path search engine.
// Clears both memories in a sweep after reset; depends on gasp_pkg.
module gasp_tile_store (
   input  logic                         clock,
   input  logic                         reset,
   input  gasp_pkg::tile_port_type      port,
   output logic [gasp_pkg::FLAG_W-1:0]  flags_rd,
   output logic [gasp_pkg::NODE_W-1:0]  slot_rd,
   output logic                         busy
);

   logic [gasp_pkg::FLAG_W-1:0]  flag_mem [2**gasp_pkg::TILE_AW];
   logic [gasp_pkg::NODE_W-1:0]  slot_mem [2**gasp_pkg::TILE_AW];
   logic [gasp_pkg::TILE_AW-1:0] clr_ff;
   logic [gasp_pkg::TILE_AW-1:0] clr_in;
   logic                         busy_ff;
   logic                         busy_in;
   logic                         flag_we;
   logic [gasp_pkg::TILE_AW-1:0] flag_wa;
   logic [gasp_pkg::FLAG_W-1:0]  flag_wd;
   logic                         slot_we;
   logic [gasp_pkg::TILE_AW-1:0] slot_wa;
   logic [gasp_pkg::NODE_W-1:0]  slot_wd;

   always_comb begin
      clr_in = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == '1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff <= clr_in;
         busy_ff <= busy_in;
      end
   end

   assign flag_we = busy_ff || port.flag_we;
   assign flag_wa = busy_ff ? clr_ff : port.flag_wa;
   assign flag_wd = busy_ff ? '0 : port.flag_wd;
   assign slot_we = busy_ff || port.slot_we;
   assign slot_wa = busy_ff ? clr_ff : port.slot_wa;
   assign slot_wd = busy_ff ? '0 : port.slot_wd;

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flags_rd <= flag_mem[port.flag_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd <= slot_mem[port.slot_ra];
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/grid_astar_path_search.sv =====
// Grid A* path search engine: tile flag writes and 8-connected searches.
// A tile write goes straight to the response state. A search runs the setup states S_START and
// S_INIT, then pops and expands nodes, walking the open list on each insertion, and at the end
// clears the tile slot of every created node; the single read address of the node memories and
// the list walk set its running time. Reset is synchronous; afterwards a clearing pass of the
// tile memories runs, during which no transaction is accepted (configuration writes are taken).
module grid_astar_path_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [gasp_pkg::COORD_W-1:0]        req_tile_x,
   input  logic [gasp_pkg::COORD_W-1:0]        req_tile_y,
   input  logic                                req_tile_block,
   input  logic                                req_tile_door,
   input  logic                                req_tile_temp_block,
   input  logic [gasp_pkg::COORD_W-1:0]        req_from_x,
   input  logic [gasp_pkg::COORD_W-1:0]        req_from_y,
   input  logic [gasp_pkg::COORD_W-1:0]        req_to_x,
   input  logic [gasp_pkg::COORD_W-1:0]        req_to_y,
   input  logic [gasp_pkg::DIST_W-1:0]         req_min_dist,
   input  logic [gasp_pkg::HINT_W-1:0]         req_step_hint,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [gasp_pkg::DIR_W-1:0]          rsp_first_dir,
   output logic [gasp_pkg::COST_W-1:0]         rsp_path_cost,
   output logic [gasp_pkg::COORD_W-1:0]        rsp_best_x,
   output logic [gasp_pkg::COORD_W-1:0]        rsp_best_y,
   output logic [gasp_pkg::DIST_W-1:0]         rsp_best_dist,
   output logic [gasp_pkg::COST_W-1:0]         rsp_best_cost,
   output logic [gasp_pkg::DIR_W-1:0]          rsp_best_dir,
   output logic [gasp_pkg::HINT_W-1:0]         rsp_nodes_used,
   input  logic                                csr_we,
   input  logic [gasp_pkg::CSR_AW-1:0]         csr_index,
   input  logic [gasp_pkg::CSR_DW-1:0]         csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_INIT, S_POP, S_POP2, S_NB, S_CHK, S_OFF2, S_OFF4,
      S_UPD, S_WALK, S_LINK1, S_LINK2, S_CLR_RD, S_CLR_WR, S_DONE
   } state_type;

   localparam int CW = gasp_pkg::COORD_W;
   localparam int NW = gasp_pkg::NODE_W;
   localparam int AW = gasp_pkg::NODE_AW;

   state_type state_ff, state_in;
   gasp_pkg::rect_type rect_ff, rect_in;
   gasp_pkg::status_type res_status_ff, res_status_in;
   logic [2:0]                     k_ff, k_in;
   logic [1:0]                     step_ff, step_in;
   logic [CW:0]                    chk_x_ff, chk_x_in, chk_y_ff, chk_y_in;
   logic [CW:0]                    off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic [CW-1:0]                  tx_ff, tx_in, ty_ff, ty_in;
   logic [CW-1:0]                  ex_x_ff, ex_x_in, ex_y_ff, ex_y_in;
   logic [gasp_pkg::COST_W-1:0]    ex_cost_ff, ex_cost_in;
   logic [gasp_pkg::DIR_W-1:0]     ex_dir_ff, ex_dir_in;
   logic [gasp_pkg::DIST_W-1:0]    mind_ff, mind_in;
   logic [gasp_pkg::HINT_W-1:0]    budget_ff, budget_in;
   logic [NW-1:0]                  count_ff, count_in, head_ff, head_in;
   logic [NW-1:0]                  on_ff, on_in, cur_ff, cur_in, prv_ff, prv_in;
   logic [NW-1:0]                  clr_ff, clr_in;
   logic                           bhit_ff, bhit_in, goal_ff, goal_in, isnew_ff, isnew_in;
   logic [gasp_pkg::BESTD_W-1:0]   bestd_ff, bestd_in;
   logic [CW-1:0]                  best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic [gasp_pkg::COST_W-1:0]    best_cost_ff, best_cost_in;
   logic [gasp_pkg::DIR_W-1:0]     best_dir_ff, best_dir_in;
   logic [gasp_pkg::DIR_W-1:0]     goal_dir_ff, goal_dir_in;
   logic [gasp_pkg::COST_W-1:0]    goal_cost_ff, goal_cost_in;
   logic [gasp_pkg::COST_W-1:0]    off_g_ff, off_g_in;
   logic [gasp_pkg::TOTAL_W-1:0]   off_t_ff, off_t_in;
   logic [gasp_pkg::DIR_W-1:0]     off_d_ff, off_d_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [gasp_pkg::DIR_W-1:0]     rsp_first_dir_ff, rsp_first_dir_in;
   logic [gasp_pkg::COST_W-1:0]    rsp_path_cost_ff, rsp_path_cost_in;
   logic [CW-1:0]                  rsp_best_x_ff, rsp_best_x_in, rsp_best_y_ff, rsp_best_y_in;
   logic [gasp_pkg::DIST_W-1:0]    rsp_best_dist_ff, rsp_best_dist_in;
   logic [gasp_pkg::COST_W-1:0]    rsp_best_cost_ff, rsp_best_cost_in;
   logic [gasp_pkg::DIR_W-1:0]     rsp_best_dir_ff, rsp_best_dir_in;
   logic [gasp_pkg::HINT_W-1:0]    rsp_nodes_ff, rsp_nodes_in;

   logic [gasp_pkg::TILE_AW-1:0]   pos_mem [gasp_pkg::NODE_POOL];
   logic [gasp_pkg::COST_W-1:0]    cost_mem [gasp_pkg::NODE_POOL];
   logic [gasp_pkg::TOTAL_W-1:0]   total_mem [gasp_pkg::NODE_POOL];
   logic [NW-1:0]                  prev_mem [gasp_pkg::NODE_POOL];
   logic [NW-1:0]                  next_mem [gasp_pkg::NODE_POOL];
   logic [gasp_pkg::DIR_W-1:0]     dir_mem [gasp_pkg::NODE_POOL];
   logic                           vis_mem [gasp_pkg::NODE_POOL];

   logic [AW-1:0]                  nra;
   logic [gasp_pkg::TILE_AW-1:0]   pos_rd, pos_wd;
   logic [gasp_pkg::COST_W-1:0]    cost_rd, cost_wd;
   logic [gasp_pkg::TOTAL_W-1:0]   total_rd, total_wd;
   logic [NW-1:0]                  prev_rd, prev_wd, next_rd, next_wd;
   logic [gasp_pkg::DIR_W-1:0]     dir_rd, dir_wd;
   logic                           vis_rd, vis_wd;
   logic                           pos_we, cost_we, total_we, prev_we, next_we, dir_we, vis_we;
   logic [AW-1:0]                  pos_wa, cost_wa, total_wa, prev_wa, next_wa, dir_wa, vis_wa;

   gasp_pkg::tile_port_type        tport;
   logic [gasp_pkg::FLAG_W-1:0]    flags_rd;
   logic [NW-1:0]                  slot_rd;
   logic                           tiles_busy;

   logic [gasp_pkg::DIST_W-1:0]    req_dist;
   logic [gasp_pkg::LIM_W-1:0]     req_lim;
   logic [gasp_pkg::HINT_W-1:0]    req_cap, req_budget;
   logic                           req_reject;
   logic                           accept;
   logic                           pass_chk;
   logic [CW-1:0]                  pop_x, pop_y;
   logic [gasp_pkg::DIST_W-1:0]    pop_dist;
   logic [gasp_pkg::COST_W-1:0]    off_g_calc;
   logic [gasp_pkg::TOTAL_W-1:0]   off_t_calc;
   logic [NW-1:0]                  slot_m1;
   logic                           advance;
   logic                           rsp_free;
   logic                           found;

   gasp_tile_store u_tiles (
      .clock    (clock),
      .reset    (reset),
      .port     (tport),
      .flags_rd (flags_rd),
      .slot_rd  (slot_rd),
      .busy     (tiles_busy)
   );

   assign req_stall = (state_ff != S_IDLE) || tiles_busy;
   assign accept = req_valid && !req_stall;

   assign req_dist = gasp_pkg::mdist(req_from_x, req_from_y, req_to_x, req_to_y);
   assign req_lim = gasp_pkg::LIM_W'(req_dist) * gasp_pkg::LIM_W'(gasp_pkg::BUDGET_PER_STEP)
                    + gasp_pkg::LIM_W'(gasp_pkg::BUDGET_BASE);
   assign req_cap = (req_lim < gasp_pkg::LIM_W'(gasp_pkg::NODE_POOL)) ?
                    req_lim[gasp_pkg::HINT_W-1:0] : gasp_pkg::HINT_W'(gasp_pkg::NODE_POOL);
   assign req_budget = (req_step_hint != '0 && req_step_hint < req_cap) ? req_step_hint : req_cap;
   assign req_reject = req_from_x == '0 || req_from_x == gasp_pkg::MAP_LAST ||
                       req_from_y == '0 || req_from_y == gasp_pkg::MAP_LAST ||
                       req_to_x == '0 || req_to_x == gasp_pkg::MAP_LAST ||
                       req_to_y == '0 || req_to_y == gasp_pkg::MAP_LAST ||
                       req_dist == req_min_dist;

   assign pass_chk = gasp_pkg::passable(chk_x_ff, chk_y_ff, flags_rd, rect_ff);
   assign pop_x = pos_rd[CW-1:0];
   assign pop_y = pos_rd[2*CW-1:CW];
   assign pop_dist = gasp_pkg::mdist(pop_x, pop_y, tx_ff, ty_ff);
   assign off_g_calc = ex_cost_ff + (k_ff[2] ? gasp_pkg::STEP_DIAG : gasp_pkg::STEP_STRAIGHT);
   assign off_t_calc = gasp_pkg::TOTAL_W'(off_g_calc) + gasp_pkg::TOTAL_W'(
                       gasp_pkg::heur(off_x_ff[CW-1:0], off_y_ff[CW-1:0], tx_ff, ty_ff));
   assign slot_m1 = slot_rd - 1'b1;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign found = res_status_ff == gasp_pkg::ST_FOUND;

   always_comb begin
      rect_in = rect_ff;
      if (csr_we) begin
         case (gasp_pkg::csr_index_type'(csr_index))
            gasp_pkg::CSR_USE_RECT: rect_in.enable = csr_wdata[0];
            gasp_pkg::CSR_X_LOW:    rect_in.x_low = csr_wdata;
            gasp_pkg::CSR_X_HIGH:   rect_in.x_high = csr_wdata;
            gasp_pkg::CSR_Y_LOW:    rect_in.y_low = csr_wdata;
            gasp_pkg::CSR_Y_HIGH:   rect_in.y_high = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      res_status_in = res_status_ff;
      k_in = k_ff;
      step_in = step_ff;
      chk_x_in = chk_x_ff;
      chk_y_in = chk_y_ff;
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      ex_x_in = ex_x_ff;
      ex_y_in = ex_y_ff;
      ex_cost_in = ex_cost_ff;
      ex_dir_in = ex_dir_ff;
      mind_in = mind_ff;
      budget_in = budget_ff;
      count_in = count_ff;
      head_in = head_ff;
      on_in = on_ff;
      cur_in = cur_ff;
      prv_in = prv_ff;
      clr_in = clr_ff;
      bhit_in = bhit_ff;
      goal_in = goal_ff;
      isnew_in = isnew_ff;
      bestd_in = bestd_ff;
      best_x_in = best_x_ff;
      best_y_in = best_y_ff;
      best_cost_in = best_cost_ff;
      best_dir_in = best_dir_ff;
      goal_dir_in = goal_dir_ff;
      goal_cost_in = goal_cost_ff;
      off_g_in = off_g_ff;
      off_t_in = off_t_ff;
      off_d_in = off_d_ff;
      advance = 1'b0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_first_dir_in = rsp_first_dir_ff;
      rsp_path_cost_in = rsp_path_cost_ff;
      rsp_best_x_in = rsp_best_x_ff;
      rsp_best_y_in = rsp_best_y_ff;
      rsp_best_dist_in = rsp_best_dist_ff;
      rsp_best_cost_in = rsp_best_cost_ff;
      rsp_best_dir_in = rsp_best_dir_ff;
      rsp_nodes_in = rsp_nodes_ff;

      nra = '0;
      pos_we = 1'b0;  pos_wa = '0;   pos_wd = '0;
      cost_we = 1'b0; cost_wa = '0;  cost_wd = '0;
      total_we = 1'b0; total_wa = '0; total_wd = '0;
      prev_we = 1'b0; prev_wa = '0;  prev_wd = '0;
      next_we = 1'b0; next_wa = '0;  next_wd = '0;
      dir_we = 1'b0;  dir_wa = '0;   dir_wd = '0;
      vis_we = 1'b0;  vis_wa = '0;   vis_wd = 1'b0;
      tport = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == gasp_pkg::ACT_WRITE) begin
                  tport.flag_we = 1'b1;
                  tport.flag_wa = {req_tile_y, req_tile_x};
                  tport.flag_wd = {req_tile_temp_block, req_tile_door, req_tile_block};
                  res_status_in = gasp_pkg::ST_WRITE;
                  state_in = S_DONE;
               end else begin
                  tx_in = req_to_x;
                  ty_in = req_to_y;
                  ex_x_in = req_from_x;
                  ex_y_in = req_from_y;
                  mind_in = req_min_dist;
                  budget_in = req_budget;
                  count_in = '0;
                  bhit_in = 1'b0;
                  goal_in = 1'b0;
                  bestd_in = gasp_pkg::BESTD_INIT;
                  chk_x_in = {1'b0, req_to_x};
                  chk_y_in = {1'b0, req_to_y};
                  if (req_reject) begin
                     res_status_in = gasp_pkg::ST_REJECT;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_START;
                  end
               end
            end
         end
         S_START: begin
            if (mind_ff == '0 && !pass_chk) begin
               res_status_in = gasp_pkg::ST_REJECT;
               state_in = S_DONE;
            end else begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            pos_we = 1'b1;   pos_wd = {ex_y_ff, ex_x_ff};
            cost_we = 1'b1;  cost_wd = '0;
            total_we = 1'b1;
            total_wd = gasp_pkg::TOTAL_W'(gasp_pkg::heur(ex_x_ff, ex_y_ff, tx_ff, ty_ff));
            prev_we = 1'b1;  prev_wd = gasp_pkg::NODE_NIL;
            next_we = 1'b1;  next_wd = gasp_pkg::NODE_NIL;
            dir_we = 1'b1;   dir_wd = gasp_pkg::DIR_NONE;
            vis_we = 1'b1;   vis_wd = 1'b0;
            tport.slot_we = 1'b1;
            tport.slot_wa = {ex_y_ff, ex_x_ff};
            tport.slot_wd = NW'(1);
            head_in = '0;
            count_in = NW'(1);
            state_in = S_POP;
         end
         S_POP: begin
            if (head_ff == gasp_pkg::NODE_NIL || bhit_ff) begin
               clr_in = '0;
               state_in = S_CLR_RD;
            end else begin
               nra = head_ff[AW-1:0];
               state_in = S_POP2;
            end
         end
         S_POP2: begin
            if (gasp_pkg::BESTD_W'(pop_dist) < bestd_ff) begin
               bestd_in = gasp_pkg::BESTD_W'(pop_dist);
               best_x_in = pop_x;
               best_y_in = pop_y;
               best_cost_in = cost_rd;
               best_dir_in = dir_rd;
            end
            if (pop_dist == mind_ff) begin
               goal_in = 1'b1;
               goal_dir_in = dir_rd;
               goal_cost_in = cost_rd;
               clr_in = '0;
               state_in = S_CLR_RD;
            end else begin
               head_in = next_rd;
               if (next_rd != gasp_pkg::NODE_NIL) begin
                  prev_we = 1'b1;
                  prev_wa = next_rd[AW-1:0];
                  prev_wd = gasp_pkg::NODE_NIL;
               end
               vis_we = 1'b1;
               vis_wa = head_ff[AW-1:0];
               vis_wd = 1'b1;
               ex_x_in = pop_x;
               ex_y_in = pop_y;
               ex_cost_in = cost_rd;
               ex_dir_in = dir_rd;
               k_in = '0;
               state_in = S_NB;
            end
         end
         S_NB: begin
            chk_x_in = gasp_pkg::nb_x(ex_x_ff, k_ff);
            chk_y_in = gasp_pkg::nb_y(ex_y_ff, k_ff);
            off_x_in = chk_x_in;
            off_y_in = chk_y_in;
            off_d_in = (ex_dir_ff != gasp_pkg::DIR_NONE) ? ex_dir_ff :
                       gasp_pkg::DIR_W'(k_ff) + 1'b1;
            step_in = '0;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!pass_chk) begin
               advance = 1'b1;
            end else if (step_ff == 2'd0 && k_ff[2]) begin
               step_in = 2'd1;
               chk_x_in = off_x_ff;
               chk_y_in = {1'b0, ex_y_ff};
            end else if (step_ff == 2'd1) begin
               step_in = 2'd2;
               chk_x_in = {1'b0, ex_x_ff};
               chk_y_in = off_y_ff;
            end else if (off_x_ff == '0 || off_y_ff == '0) begin
               advance = 1'b1;
            end else begin
               off_g_in = off_g_calc;
               off_t_in = off_t_calc;
               state_in = S_OFF2;
            end
         end
         S_OFF2: begin
            if (slot_rd != '0) begin
               on_in = slot_m1;
               nra = slot_m1[AW-1:0];
               state_in = S_OFF4;
            end else if (gasp_pkg::HINT_W'(count_ff) >= budget_ff) begin
               bhit_in = 1'b1;
               advance = 1'b1;
            end else begin
               on_in = count_ff;
               count_in = count_ff + 1'b1;
               isnew_in = 1'b1;
               state_in = S_UPD;
            end
         end
         S_OFF4: begin
            if (total_rd <= off_t_ff) begin
               advance = 1'b1;
            end else begin
               isnew_in = 1'b0;
               if (!vis_rd) begin
                  if (prev_rd != gasp_pkg::NODE_NIL) begin
                     next_we = 1'b1;
                     next_wa = prev_rd[AW-1:0];
                     next_wd = next_rd;
                  end else begin
                     head_in = next_rd;
                  end
                  if (next_rd != gasp_pkg::NODE_NIL) begin
                     prev_we = 1'b1;
                     prev_wa = next_rd[AW-1:0];
                     prev_wd = prev_rd;
                  end
               end
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            cost_we = 1'b1;  cost_wa = on_ff[AW-1:0];  cost_wd = off_g_ff;
            total_we = 1'b1; total_wa = on_ff[AW-1:0]; total_wd = off_t_ff;
            vis_we = 1'b1;   vis_wa = on_ff[AW-1:0];   vis_wd = 1'b0;
            dir_we = 1'b1;   dir_wa = on_ff[AW-1:0];   dir_wd = off_d_ff;
            if (isnew_ff) begin
               pos_we = 1'b1;
               pos_wa = on_ff[AW-1:0];
               pos_wd = {off_y_ff[CW-1:0], off_x_ff[CW-1:0]};
               tport.slot_we = 1'b1;
               tport.slot_wa = {off_y_ff[CW-1:0], off_x_ff[CW-1:0]};
               tport.slot_wd = on_ff + 1'b1;
            end
            prv_in = gasp_pkg::NODE_NIL;
            cur_in = head_ff;
            nra = head_ff[AW-1:0];
            state_in = (head_ff == gasp_pkg::NODE_NIL) ? S_LINK1 : S_WALK;
         end
         S_WALK: begin
            if (total_rd < off_t_ff) begin
               prv_in = cur_ff;
               cur_in = next_rd;
               nra = next_rd[AW-1:0];
               if (next_rd == gasp_pkg::NODE_NIL) begin
                  state_in = S_LINK1;
               end
            end else begin
               state_in = S_LINK1;
            end
         end
         S_LINK1: begin
            next_we = 1'b1; next_wa = on_ff[AW-1:0]; next_wd = cur_ff;
            prev_we = 1'b1; prev_wa = on_ff[AW-1:0]; prev_wd = prv_ff;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            if (prv_ff != gasp_pkg::NODE_NIL) begin
               next_we = 1'b1;
               next_wa = prv_ff[AW-1:0];
               next_wd = on_ff;
            end else begin
               head_in = on_ff;
            end
            if (cur_ff != gasp_pkg::NODE_NIL) begin
               prev_we = 1'b1;
               prev_wa = cur_ff[AW-1:0];
               prev_wd = on_ff;
            end
            advance = 1'b1;
         end
         S_CLR_RD: begin
            nra = clr_ff[AW-1:0];
            state_in = S_CLR_WR;
         end
         S_CLR_WR: begin
            tport.slot_we = 1'b1;
            tport.slot_wa = pos_rd;
            tport.slot_wd = '0;
            if (clr_ff + 1'b1 == count_ff) begin
               head_in = gasp_pkg::NODE_NIL;
               res_status_in = goal_ff ? gasp_pkg::ST_FOUND : gasp_pkg::ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               clr_in = clr_ff + 1'b1;
               state_in = S_CLR_RD;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_first_dir_in = '0;
               rsp_path_cost_in = '0;
               rsp_best_x_in = '0;
               rsp_best_y_in = '0;
               rsp_best_dist_in = '0;
               rsp_best_cost_in = '0;
               rsp_best_dir_in = '0;
               rsp_nodes_in = '0;
               if (found || res_status_ff == gasp_pkg::ST_NOT_FOUND) begin
                  rsp_best_x_in = best_x_ff;
                  rsp_best_y_in = best_y_ff;
                  rsp_best_dist_in = bestd_ff[gasp_pkg::DIST_W-1:0];
                  rsp_best_cost_in = best_cost_ff;
                  rsp_best_dir_in = best_dir_ff;
                  rsp_nodes_in = gasp_pkg::HINT_W'(count_ff);
               end
               if (found) begin
                  rsp_first_dir_in = goal_dir_ff;
                  rsp_path_cost_in = goal_cost_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (advance) begin
         if (k_ff == 3'd7) begin
            state_in = S_POP;
         end else begin
            k_in = k_ff + 1'b1;
            state_in = S_NB;
         end
      end

      tport.flag_ra = {chk_y_in[CW-1:0], chk_x_in[CW-1:0]};
      tport.slot_ra = {off_y_ff[CW-1:0], off_x_ff[CW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_wa] <= pos_wd;
      if (cost_we) cost_mem[cost_wa] <= cost_wd;
      if (total_we) total_mem[total_wa] <= total_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (dir_we) dir_mem[dir_wa] <= dir_wd;
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      pos_rd <= pos_mem[nra];
      cost_rd <= cost_mem[nra];
      total_rd <= total_mem[nra];
      prev_rd <= prev_mem[nra];
      next_rd <= next_mem[nra];
      dir_rd <= dir_mem[nra];
      vis_rd <= vis_mem[nra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rect_ff <= '{enable: 1'b0, x_low: '0, x_high: '1, y_low: '0, y_high: '1};
         count_ff <= '0;
         budget_ff <= '0;
         head_ff <= gasp_pkg::NODE_NIL;
         bhit_ff <= 1'b0;
         goal_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rect_ff <= rect_in;
         count_ff <= count_in;
         budget_ff <= budget_in;
         head_ff <= head_in;
         bhit_ff <= bhit_in;
         goal_ff <= goal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_status_ff <= res_status_in;
      k_ff <= k_in;
      step_ff <= step_in;
      chk_x_ff <= chk_x_in;
      chk_y_ff <= chk_y_in;
      off_x_ff <= off_x_in;
      off_y_ff <= off_y_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      ex_x_ff <= ex_x_in;
      ex_y_ff <= ex_y_in;
      ex_cost_ff <= ex_cost_in;
      ex_dir_ff <= ex_dir_in;
      mind_ff <= mind_in;
      on_ff <= on_in;
      cur_ff <= cur_in;
      prv_ff <= prv_in;
      clr_ff <= clr_in;
      isnew_ff <= isnew_in;
      bestd_ff <= bestd_in;
      best_x_ff <= best_x_in;
      best_y_ff <= best_y_in;
      best_cost_ff <= best_cost_in;
      best_dir_ff <= best_dir_in;
      goal_dir_ff <= goal_dir_in;
      goal_cost_ff <= goal_cost_in;
      off_g_ff <= off_g_in;
      off_t_ff <= off_t_in;
      off_d_ff <= off_d_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_dir_ff <= rsp_first_dir_in;
      rsp_path_cost_ff <= rsp_path_cost_in;
      rsp_best_x_ff <= rsp_best_x_in;
      rsp_best_y_ff <= rsp_best_y_in;
      rsp_best_dist_ff <= rsp_best_dist_in;
      rsp_best_cost_ff <= rsp_best_cost_in;
      rsp_best_dir_ff <= rsp_best_dir_in;
      rsp_nodes_ff <= rsp_nodes_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_first_dir = rsp_first_dir_ff;
   assign rsp_path_cost = rsp_path_cost_ff;
   assign rsp_best_x = rsp_best_x_ff;
   assign rsp_best_y = rsp_best_y_ff;
   assign rsp_best_dist = rsp_best_dist_ff;
   assign rsp_best_cost = rsp_best_cost_ff;
   assign rsp_best_dir = rsp_best_dir_ff;
   assign rsp_nodes_used = rsp_nodes_ff;

   a_budget_bound: assert property (@(posedge clock) disable iff (reset)
      gasp_pkg::HINT_W'(count_ff) <= budget_ff)
      else $error("node count exceeds the node budget");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted transaction did not start processing");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP2 |-> head_ff < count_ff)
      else $error("open list head refers to an uncreated node");

endmodule
